@@ rtl/uidw_pkg.sv @@
// ----------------------------------------------------------------------------
// Descriptor walker package
// Shared types, descriptor codes and result codes of the descriptor walker.
// ----------------------------------------------------------------------------
package uidw_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;
   localparam int unsigned SLOT_COUNT = 8;
   localparam int unsigned SLOT_W = 3;

   localparam logic [7:0] TYPE_INTERFACE = 8'h04;
   localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
   localparam logic [7:0] TYPE_HID       = 8'h21;
   localparam logic [7:0] LEN_INTERFACE  = 8'd9;
   localparam logic [7:0] LEN_ENDPOINT   = 8'd7;

   localparam logic [SLOT_W-1:0] SLOT_INTERFACE = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_OUT_BASE  = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_IN_BASE   = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_HID       = 3'd7;

   localparam logic [1:0] ST_PARSED     = 2'd0;
   localparam logic [1:0] ST_NO_IFACE   = 2'd1;
   localparam logic [1:0] ST_OVERRUN    = 2'd2;
   localparam logic [1:0] ST_ZERO_LEN   = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SEEK,
      PH_WALK
   } uidw_phase_type;

   typedef struct packed {
      logic        start_req;
      logic [7:0]  data_byte;
      logic [15:0] total_length;
   } uidw_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] skip_length;
      logic [15:0] interface_pos;
      logic [15:0] iso_out_pos;
      logic [15:0] bulk_out_pos;
      logic [15:0] intr_out_pos;
      logic [15:0] iso_in_pos;
      logic [15:0] bulk_in_pos;
      logic [15:0] intr_in_pos;
      logic [15:0] hid_pos;
   } uidw_rsp_type;

   typedef struct packed {
      logic byte_zero;
      logic byte_lt2;
      logic is_interface;
      logic is_endpoint;
      logic is_hid;
   } uidw_class_type;

   typedef struct packed {
      uidw_req_type   req;
      uidw_class_type cls;
   } uidw_item_type;

endpackage

@@ rtl/usb_interface_descriptor_walker_core.sv @@
// ----------------------------------------------------------------------------
// USB interface descriptor walker
// Finds the first interface in a configuration descriptor and reports its
// endpoints and HID descriptor.
// ----------------------------------------------------------------------------
// Bytes are taken one per clock into a short queue and walked at one byte per
// clock, so the sustained rate is one byte a cycle; a result is written to the
// output register as the last byte of its walk is taken from the queue. The
// walker stalls only when a finished result is due while the previous one is
// still waiting in the output register, and the queue of QUEUE_DEPTH bytes
// then fills.
module usb_interface_descriptor_walker_core #(
   parameter int unsigned QUEUE_DEPTH = uidw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  uidw_pkg::uidw_req_type req_data,
   output logic                   empty,
   input  logic                   pop,
   output uidw_pkg::uidw_rsp_type rsp_data
);
   import uidw_pkg::*;

   logic          q_valid;
   logic          q_take;
   uidw_item_type q_item;

   uidw_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_take   (q_take),
      .q_item   (q_item)
   );

   uidw_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_take   (q_take),
      .q_item   (q_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

@@ rtl/uidw_front.sv @@
// ----------------------------------------------------------------------------
// Descriptor walker front end
// Accepts bytes, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module uidw_front #(
   parameter int unsigned QUEUE_DEPTH = uidw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  uidw_pkg::uidw_req_type req_data,
   output logic                   q_valid,
   input  logic                   q_take,
   output uidw_pkg::uidw_item_type q_item
);
   import uidw_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   uidw_item_type  entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   uidw_item_type  item_in;
   logic           do_push;
   logic           do_take;

   always_comb begin
      item_in.req              = req_data;
      item_in.cls.byte_zero    = (req_data.data_byte == 8'd0);
      item_in.cls.byte_lt2     = (req_data.data_byte < 8'd2);
      item_in.cls.is_interface = (req_data.data_byte == TYPE_INTERFACE);
      item_in.cls.is_endpoint  = (req_data.data_byte == TYPE_ENDPOINT);
      item_in.cls.is_hid       = (req_data.data_byte == TYPE_HID);
   end

   assign full    = (count_ff == CNT_FULL);
   assign q_valid = (count_ff != '0);
   assign q_item  = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_take = q_take && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_take) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

@@ rtl/uidw_back.sv @@
// ----------------------------------------------------------------------------
// Descriptor walker back end
// Walks descriptors one byte a cycle unless output stalls; holds the result.
// ----------------------------------------------------------------------------
module uidw_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_take,
   input  uidw_pkg::uidw_item_type q_item,
   output logic                    empty,
   input  logic                    pop,
   output uidw_pkg::uidw_rsp_type  rsp_data
);
   import uidw_pkg::*;

   uidw_phase_type phase_ff, phase_in;
   logic [7:0]     byte_in_desc_ff, byte_in_desc_in;
   logic [7:0]     desc_len_ff, desc_len_in;
   logic [7:0]     desc_type_ff, desc_type_in;
   logic [7:0]     ep_address_ff, ep_address_in;
   logic [15:0]    desc_start_ff, desc_start_in;
   logic [15:0]    remaining_ff, remaining_in;
   logic [15:0]    consumed_ff, consumed_in;
   logic [15:0]    found_ff [SLOT_COUNT];
   logic [15:0]    found_in [SLOT_COUNT];
   logic           rsp_valid_ff, rsp_valid_in;
   uidw_rsp_type   rsp_ff, rsp_in;
   logic           produce;
   logic [1:0]     status;
   logic           out_free;
   logic           advance;

   always_comb begin
      uidw_phase_type ph;
      logic [7:0]     bid;
      logic [7:0]     d;
      logic [15:0]    rem;
      logic [15:0]    cons;
      logic [15:0]    start_pos;
      logic [SLOT_W-1:0] slot;
      logic           finished;
      logic           ignore;

      d         = q_item.req.data_byte;
      ignore    = !q_item.req.start_req && (phase_ff == PH_IDLE);
      ph        = q_item.req.start_req ? PH_SEEK : phase_ff;
      bid       = q_item.req.start_req ? 8'd0 : byte_in_desc_ff;
      rem       = q_item.req.start_req ? q_item.req.total_length : remaining_ff;
      cons      = q_item.req.start_req ? 16'd0 : consumed_ff;
      start_pos = desc_start_ff + 16'd1;
      slot      = '0;
      finished  = 1'b0;
      status    = ST_PARSED;

      phase_in        = ph;
      byte_in_desc_in = bid;
      desc_len_in     = desc_len_ff;
      desc_type_in    = desc_type_ff;
      ep_address_in   = ep_address_ff;
      desc_start_in   = desc_start_ff;
      remaining_in    = rem;
      consumed_in     = cons;
      for (int k = 0; k < SLOT_COUNT; k++) begin
         found_in[k] = q_item.req.start_req ? 16'd0 : found_ff[k];
      end

      if (bid == 8'd0) begin
         desc_len_in   = d;
         desc_start_in = cons;
         desc_type_in  = 8'd0;
         ep_address_in = 8'd0;
         if (ph == PH_SEEK || q_item.cls.byte_lt2 || rem < 16'd2) begin
            if ({8'd0, d} > rem) begin
               finished = 1'b1;
               status   = ST_OVERRUN;
            end else if (q_item.cls.byte_zero) begin
               finished = 1'b1;
               status   = ST_ZERO_LEN;
            end else begin
               remaining_in = rem - {8'd0, d};
               consumed_in  = cons + {8'd0, d};
               if (remaining_in == 16'd0) begin
                  finished = 1'b1;
                  status   = (ph == PH_SEEK) ? ST_NO_IFACE : ST_PARSED;
               end
            end
         end
      end else if (bid == 8'd1) begin
         desc_type_in = d;
         if (ph == PH_SEEK) begin
            if (q_item.cls.is_interface && desc_len_ff == LEN_INTERFACE) begin
               found_in[SLOT_INTERFACE] = start_pos;
            end
         end else if (q_item.cls.is_interface) begin
            finished = 1'b1;
            status   = ST_PARSED;
         end else begin
            if (q_item.cls.is_hid && found_in[SLOT_HID] == 16'd0) begin
               found_in[SLOT_HID] = start_pos;
            end
            if ({8'd0, desc_len_ff} > rem) begin
               finished = 1'b1;
               status   = ST_OVERRUN;
            end else begin
               remaining_in = rem - {8'd0, desc_len_ff};
               consumed_in  = cons + {8'd0, desc_len_ff};
               if (remaining_in == 16'd0 &&
                   !(q_item.cls.is_endpoint && desc_len_ff == LEN_ENDPOINT)) begin
                  finished = 1'b1;
                  status   = ST_PARSED;
               end
            end
         end
      end else if (ph == PH_WALK && desc_type_ff == TYPE_ENDPOINT &&
                   desc_len_ff == LEN_ENDPOINT) begin
         if (bid == 8'd2) begin
            ep_address_in = d;
         end else if (bid == 8'd3) begin
            if (ep_address_ff[3:0] != 4'd0 && d[1:0] != 2'd0) begin
               slot = (ep_address_ff[7] ? SLOT_IN_BASE : SLOT_OUT_BASE) +
                      {1'b0, d[1:0]} - 3'd1;
               if (found_in[slot] == 16'd0) begin
                  found_in[slot] = start_pos;
               end
            end
            if (rem == 16'd0) begin
               finished = 1'b1;
               status   = ST_PARSED;
            end
         end
      end

      if (finished) begin
         phase_in        = PH_IDLE;
         byte_in_desc_in = 8'd0;
      end else if ({1'b0, bid} + 9'd1 >= {1'b0, desc_len_in}) begin
         byte_in_desc_in = 8'd0;
         if (ph == PH_SEEK && found_in[SLOT_INTERFACE] != 16'd0) begin
            phase_in = PH_WALK;
         end
      end else begin
         byte_in_desc_in = bid + 8'd1;
      end

      produce = finished && !ignore;
   end

   always_comb begin
      rsp_in.status        = status;
      rsp_in.skip_length   = consumed_in;
      rsp_in.interface_pos = found_in[0];
      rsp_in.iso_out_pos   = found_in[1];
      rsp_in.bulk_out_pos  = found_in[2];
      rsp_in.intr_out_pos  = found_in[3];
      rsp_in.iso_in_pos    = found_in[4];
      rsp_in.bulk_in_pos   = found_in[5];
      rsp_in.intr_in_pos   = found_in[6];
      rsp_in.hid_pos       = found_in[7];
   end

   assign out_free = !rsp_valid_ff || pop;
   assign advance  = q_valid && (!produce || out_free);
   assign q_take   = advance;
   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !pop;
      if (advance && produce) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         byte_in_desc_ff <= '0;
         desc_len_ff     <= '0;
         desc_type_ff    <= '0;
         ep_address_ff   <= '0;
         desc_start_ff   <= '0;
         remaining_ff    <= '0;
         consumed_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int k = 0; k < SLOT_COUNT; k++) begin
            found_ff[k] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance && !(!q_item.req.start_req && phase_ff == PH_IDLE)) begin
            phase_ff        <= phase_in;
            byte_in_desc_ff <= byte_in_desc_in;
            desc_len_ff     <= desc_len_in;
            desc_type_ff    <= desc_type_in;
            ep_address_ff   <= ep_address_in;
            desc_start_ff   <= desc_start_in;
            remaining_ff    <= remaining_in;
            consumed_ff     <= consumed_in;
            for (int k = 0; k < SLOT_COUNT; k++) begin
               found_ff[k] <= found_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Descriptor walker testbench
// Feeds configuration descriptor bytes to the walker through its input queue,
// predicts every result with a cycle-free model of the walk and checks each
// result transfer field by field, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   import uidw_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RANDOM_ITEMS = 1850;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 50;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum int {
      SINK_FREE,
      SINK_COIN,
      SINK_PATTERN,
      SINK_SLOW
   } sink_mode_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         push;
   logic         full;
   uidw_req_type req_data;
   logic         empty;
   logic         pop;
   uidw_rsp_type rsp_data;

   usb_interface_descriptor_walker_core DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   uidw_phase_type   w_phase    = PH_IDLE;
   logic [7:0]       w_byte_idx = '0;
   logic [7:0]       w_len      = '0;
   logic [7:0]       w_type     = '0;
   logic [7:0]       w_addr     = '0;
   logic [15:0]      w_start    = '0;
   logic [15:0]      w_remaining = '0;
   logic [15:0]      w_consumed = '0;
   logic [7:0][15:0] w_found    = '0;

   uidw_rsp_type expected_results[$];
   logic [7:0]   cfg_bytes[$];
   int           error_count   = 0;
   int           cycle_count   = 0;
   int           tx_burst_left = 0;
   int           hold_requests = 0;
   int           holds_done    = 0;

   function automatic uidw_rsp_type close_walk(input logic [1:0] st);
      uidw_rsp_type r;
      r.status        = st;
      r.skip_length   = w_consumed;
      r.interface_pos = w_found[SLOT_INTERFACE];
      r.iso_out_pos   = w_found[1];
      r.bulk_out_pos  = w_found[2];
      r.intr_out_pos  = w_found[3];
      r.iso_in_pos    = w_found[4];
      r.bulk_in_pos   = w_found[5];
      r.intr_in_pos   = w_found[6];
      r.hid_pos       = w_found[SLOT_HID];
      w_phase    = PH_IDLE;
      w_byte_idx = '0;
      return r;
   endfunction

   function automatic void take_desc();
      w_consumed  = w_consumed + {8'd0, w_len};
      w_remaining = w_remaining - {8'd0, w_len};
   endfunction

   function automatic bit walk_byte(input uidw_req_type item, output uidw_rsp_type res);
      logic [7:0]        d;
      logic [SLOT_W-1:0] slot;
      bit                is_ep;
      d   = item.data_byte;
      res = '0;
      if (item.start_req) begin
         w_remaining = item.total_length;
         w_consumed  = '0;
         w_found     = '0;
         w_phase     = PH_SEEK;
         w_byte_idx  = '0;
      end else if (w_phase == PH_IDLE) begin
         return 1'b0;
      end
      if (w_byte_idx == 8'd0) begin
         w_len   = d;
         w_start = w_consumed;
         w_type  = '0;
         w_addr  = '0;
         if (w_phase == PH_SEEK || d < 8'd2 || w_remaining < 16'd2) begin
            if ({8'd0, d} > w_remaining) begin
               res = close_walk(ST_OVERRUN);
               return 1'b1;
            end
            if (d == 8'd0) begin
               res = close_walk(ST_ZERO_LEN);
               return 1'b1;
            end
            take_desc();
            if (w_remaining == 16'd0) begin
               res = close_walk(w_phase == PH_SEEK ? ST_NO_IFACE : ST_PARSED);
               return 1'b1;
            end
         end
      end else if (w_byte_idx == 8'd1) begin
         w_type = d;
         if (w_phase == PH_SEEK) begin
            if (d == TYPE_INTERFACE && w_len == LEN_INTERFACE)
               w_found[SLOT_INTERFACE] = w_start + 16'd1;
         end else begin
            if (d == TYPE_INTERFACE) begin
               res = close_walk(ST_PARSED);
               return 1'b1;
            end
            if (d == TYPE_HID && w_found[SLOT_HID] == 16'd0)
               w_found[SLOT_HID] = w_start + 16'd1;
            if ({8'd0, w_len} > w_remaining) begin
               res = close_walk(ST_OVERRUN);
               return 1'b1;
            end
            take_desc();
            is_ep = (d == TYPE_ENDPOINT && w_len == LEN_ENDPOINT);
            if (w_remaining == 16'd0 && !is_ep) begin
               res = close_walk(ST_PARSED);
               return 1'b1;
            end
         end
      end else if (w_phase == PH_WALK && w_type == TYPE_ENDPOINT && w_len == LEN_ENDPOINT) begin
         if (w_byte_idx == 8'd2) begin
            w_addr = d;
         end else if (w_byte_idx == 8'd3) begin
            if (w_addr[3:0] != 4'd0 && d[1:0] != 2'd0) begin
               slot = (w_addr[7] ? SLOT_IN_BASE : SLOT_OUT_BASE) + SLOT_W'(d[1:0]) - 3'd1;
               if (w_found[slot] == 16'd0)
                  w_found[slot] = w_start + 16'd1;
            end
            if (w_remaining == 16'd0) begin
               res = close_walk(ST_PARSED);
               return 1'b1;
            end
         end
      end
      if ({1'b0, w_byte_idx} + 9'd1 >= {1'b0, w_len}) begin
         w_byte_idx = '0;
         if (w_phase == PH_SEEK && w_found[SLOT_INTERFACE] != 16'd0)
            w_phase = PH_WALK;
      end else begin
         w_byte_idx = w_byte_idx + 8'd1;
      end
      return 1'b0;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      uidw_rsp_type want;
      if (!reset && pop && !empty) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with no result expected, status %0d", rsp_data.status);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("status", 16'(want.status), 16'(rsp_data.status));
            check_field("skip_length", want.skip_length, rsp_data.skip_length);
            check_field("interface_pos", want.interface_pos, rsp_data.interface_pos);
            check_field("iso_out_pos", want.iso_out_pos, rsp_data.iso_out_pos);
            check_field("bulk_out_pos", want.bulk_out_pos, rsp_data.bulk_out_pos);
            check_field("intr_out_pos", want.intr_out_pos, rsp_data.intr_out_pos);
            check_field("iso_in_pos", want.iso_in_pos, rsp_data.iso_in_pos);
            check_field("bulk_in_pos", want.bulk_in_pos, rsp_data.bulk_in_pos);
            check_field("intr_in_pos", want.intr_in_pos, rsp_data.intr_in_pos);
            check_field("hid_pos", want.hid_pos, rsp_data.hid_pos);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // The receiver changes its stall pattern now and then, and honours a request
   // for a long hold-off by counting cycles on its own.
   initial begin : rsp_sink
      sink_mode_type mode;
      int            mode_left;
      int            tick;
      pop       = 1'b0;
      mode      = SINK_FREE;
      mode_left = 0;
      tick      = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_requests != holds_done) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end
         if (mode_left == 0) begin
            mode      = sink_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (mode)
            SINK_FREE: pop <= 1'b1;
            SINK_COIN: pop <= 1'($urandom_range(0, 1));
            SINK_PATTERN: pop <= (tick % 4) != 0;
            default: pop <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   task automatic send_byte(input logic st, input logic [7:0] b, input logic [15:0] tl);
      uidw_req_type item;
      uidw_rsp_type res;
      int           gap;
      item.start_req    = st;
      item.data_byte    = b;
      item.total_length = tl;
      @(negedge clock);
      if (tx_burst_left == 0) begin
         tx_burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      tx_burst_left--;
      push     <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full);
      if (walk_byte(item, res))
         expected_results.push_back(res);
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      push <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic add_desc(input logic [7:0] len, input logic [7:0] kind,
                           input logic [7:0] b2, input logic [7:0] b3);
      cfg_bytes.push_back(len);
      if (len > 8'd1) cfg_bytes.push_back(kind);
      if (len > 8'd2) cfg_bytes.push_back(b2);
      if (len > 8'd3) cfg_bytes.push_back(b3);
      for (int i = 4; i < int'(len); i++) cfg_bytes.push_back(8'($urandom));
   endtask

   task automatic send_config(input logic [15:0] total, input int keep);
      for (int i = 0; i < cfg_bytes.size() && i < keep; i++)
         send_byte(i == 0, cfg_bytes[i], (i == 0) ? total : 16'($urandom));
      cfg_bytes.delete();
   endtask

   task automatic test_idle_and_faults();
      send_byte(1'b0, 8'hA5, 16'h5A5A);
      send_byte(1'b1, 8'h00, 16'hFFFF);
      send_byte(1'b1, 8'hFF, 16'h0000);
      add_desc(8'd1, 8'h00, 8'h00, 8'h00);
      add_desc(8'd2, 8'h30, 8'h00, 8'h00);
      send_config(16'd3, cfg_bytes.size());
      add_desc(LEN_INTERFACE, TYPE_INTERFACE, 8'h00, 8'h01);
      send_config(16'd9, cfg_bytes.size());
   endtask

   task automatic test_interface_walk();
      add_desc(LEN_INTERFACE, TYPE_INTERFACE, 8'h00, 8'h00);
      add_desc(LEN_ENDPOINT, TYPE_ENDPOINT, 8'h01, 8'h02);
      add_desc(LEN_ENDPOINT, TYPE_ENDPOINT, 8'h03, 8'h00);
      add_desc(LEN_ENDPOINT, TYPE_ENDPOINT, 8'h80, 8'h03);
      add_desc(8'd2, TYPE_HID, 8'h00, 8'h00);
      add_desc(8'd2, TYPE_INTERFACE, 8'h00, 8'h00);
      send_config(16'hFFFF, cfg_bytes.size());
      add_desc(LEN_INTERFACE, TYPE_INTERFACE, 8'h01, 8'h00);
      add_desc(LEN_ENDPOINT, TYPE_ENDPOINT, 8'h83, 8'h03);
      send_config(16'd16, cfg_bytes.size());
      add_desc(LEN_INTERFACE, TYPE_INTERFACE, 8'h00, 8'h00);
      add_desc(8'd9, TYPE_HID, 8'h11, 8'h01);
      send_config(16'd14, 11);
      add_desc(LEN_INTERFACE, TYPE_INTERFACE, 8'h00, 8'h00);
      add_desc(LEN_ENDPOINT, TYPE_ENDPOINT, 8'h01, 8'h02);
      send_config(16'd14, 11);
      add_desc(LEN_INTERFACE, TYPE_INTERFACE, 8'h00, 8'h00);
      send_config(16'd255, 4);
      send_byte(1'b1, 8'h00, 16'h8000);
      add_desc(LEN_INTERFACE, TYPE_INTERFACE, 8'h00, 8'h00);
      add_desc(8'd3, 8'h24, 8'h00, 8'h00);
      send_config(16'd10, 10);
   endtask

   // Every transfer here ends a parse at once, so the output side backs up
   // during the hold-off and the input queue fills.
   task automatic test_backpressure();
      hold_requests++;
      repeat (40) send_byte(1'b1, 8'h00, 16'($urandom));
      wait_results_drained();
   endtask

   task automatic run_random_config(output int n_bytes);
      logic [7:0] len;
      logic [7:0] kind;
      logic [7:0] addr;
      int         total;
      int         keep;
      repeat ($urandom_range(0, 2)) begin
         len  = 8'($urandom_range(2, 12));
         kind = 8'($urandom);
         if (kind == TYPE_INTERFACE && len == LEN_INTERFACE) kind = TYPE_HID;
         add_desc(len, kind, 8'($urandom), 8'($urandom));
      end
      if ($urandom_range(0, 9) == 0) add_desc(8'd1, 8'h00, 8'h00, 8'h00);
      add_desc(LEN_INTERFACE, TYPE_INTERFACE, 8'($urandom), 8'($urandom));
      repeat ($urandom_range(0, 8)) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               addr = 8'($urandom);
               if (addr[3:0] == 4'd0 && $urandom_range(0, 5) != 0)
                  addr[3:0] = 4'($urandom_range(1, 15));
               add_desc(LEN_ENDPOINT, TYPE_ENDPOINT, addr, 8'($urandom));
            end
            6: add_desc(8'($urandom_range(2, 9)), TYPE_HID, 8'($urandom), 8'($urandom));
            7: add_desc($urandom_range(0, 1) ? 8'd6 : 8'd9, TYPE_ENDPOINT,
                        8'($urandom), 8'($urandom));
            default: begin
               kind = 8'($urandom);
               if (kind == TYPE_INTERFACE) kind = 8'h24;
               add_desc(8'($urandom_range(0, 10)), kind, 8'($urandom), 8'($urandom));
            end
         endcase
      end
      if ($urandom_range(0, 2) == 0)
         add_desc(8'($urandom_range(2, 9)), TYPE_INTERFACE, 8'($urandom), 8'($urandom));
      total = cfg_bytes.size();
      keep  = total;
      case ($urandom_range(0, 19))
         0, 1, 2: begin
            total = total - $urandom_range(1, 10);
            if (total < 0) total = 0;
         end
         3, 4: total = total + $urandom_range(1, 20);
         5: keep = $urandom_range(1, keep);
         6: total = $urandom_range(0, 65535);
         default: ;
      endcase
      n_bytes = keep;
      send_config(16'(total), keep);
   endtask

   task automatic run_noise(output int n_bytes);
      n_bytes = $urandom_range(1, 16);
      for (int i = 0; i < n_bytes; i++)
         send_byte(i == 0 || $urandom_range(0, 7) == 0, 8'($urandom), 16'($urandom));
   endtask

   task automatic test_random_stream();
      int n_sent;
      int n;
      n_sent = 0;
      while (n_sent < RANDOM_ITEMS) begin
         n = 0;
         case ($urandom_range(0, 19))
            0, 1: run_noise(n);
            2: repeat ($urandom_range(1, 4)) send_byte(1'b0, 8'($urandom), 16'($urandom));
            3: wait_results_drained();
            default: run_random_config(n);
         endcase
         n_sent += n;
      end
   endtask

   initial begin
      reset    = 1'b1;
      push     = 1'b0;
      req_data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_idle_and_faults();
      test_interface_walk();
      test_backpressure();
      test_random_stream();
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ usb_interface_descriptor_walker_core.f @@
rtl/uidw_pkg.sv
rtl/uidw_front.sv
rtl/uidw_back.sv
rtl/usb_interface_descriptor_walker_core.sv
dv/tb.sv
